// File: design/aafm_pkg.sv
`timescale 1ns / 1ps

package aafm_pkg;

  // Longest token prefix examined is BUFFER_BYTES-1 characters
  localparam int BUFFER_BYTES = 24;
  localparam int TOKEN_LEN_W  = $clog2(BUFFER_BYTES);

  localparam logic [7:0] CHAR_AT    = 8'h40;  // '@'
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_K     = 8'h4B;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [23:0] WORD_OK  = {8'h00, CHAR_K, CHAR_O};
  localparam logic [23:0] WORD_NOK = {CHAR_K, CHAR_O, CHAR_N};

  // Token value saturates here; anything above 255 never matches
  localparam logic [8:0] TOKEN_SAT = 9'd256;
  localparam int DECIMAL_BASE = 10;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RESP_PENDING = 2'd0,
    RESP_OK      = 2'd1,
    RESP_NOK     = 2'd2,
    RESP_TIMEOUT = 2'd3
  } resp_t;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_DST,
    PS_SRC,
    PS_WORD
  } parse_state_t;

  typedef enum logic [1:0] {
    CFG_OWN_ADDRESS     = 2'd0,
    CFG_EXPECTED_SOURCE = 2'd1,
    CFG_TIMEOUT_TICKS   = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  own_address;
    logic [7:0]  expected_source;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] rx_char;
  } item_t;

endpackage

// File: design/ascii_ack_frame_matcher.sv
`timescale 1ns / 1ps
// The result is registered: an input transaction passes the input register, then the result register.
// Throughput: one item per cycle while the result register can take it; the parser state updates as
// the item moves between the two registers, so a full result register stalls the input side.
// Reset (rst, synchronous): parser idle, status pending, timeout count zero,
// configuration registers back to own_address 0, expected_source 0, timeout 300.

module ascii_ack_frame_matcher import aafm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_char
  input  logic [1:0]  s_tuser,    // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [1:0] response, [7:2] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  logic  advance;
  resp_t response;
  resp_t out_resp;
  logic  out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address     <= '0;
      cfg.expected_source <= '0;
      cfg.timeout_ticks   <= 16'd300;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_OWN_ADDRESS:     cfg.own_address     <= cfg_data[7:0];
        CFG_EXPECTED_SOURCE: cfg.expected_source <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= cfg_data;
        default:             cfg                 <= cfg;
      endcase
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.operation <= op_t'(s_tuser);
      in_item.rx_char   <= s_tdata;
    end
  end

  aafm_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (in_item),
    .cfg      (cfg),
    .response (response)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_resp <= response;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_resp};

endmodule

// File: design/aafm_parser.sv
`timescale 1ns / 1ps

module aafm_parser import aafm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,   // item in the input register is applied this cycle
  input  item_t item,
  input  cfg_t  cfg,
  output resp_t response   // status after the item
);

  parse_state_t           parse_state, parse_state_next;
  logic [8:0]             token_value, token_value_next;
  logic                   token_has_digit, token_has_digit_next;
  logic                   token_bad, token_bad_next;
  logic [TOKEN_LEN_W-1:0] token_length, token_length_next;
  logic [23:0]            word_chars, word_chars_next;
  logic [1:0]             word_count, word_count_next;
  logic [15:0]            ticks_left, ticks_left_next;
  resp_t                  final_status, final_status_next;

  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] token_prod;
  logic        token_ok;
  logic        dst_match;
  logic        src_match;
  logic [23:0] word_new;

  always_comb begin
    is_digit   = (item.rx_char >= CHAR_ZERO) && (item.rx_char <= CHAR_NINE);
    digit      = 4'(item.rx_char - CHAR_ZERO);
    token_prod = 12'(token_value) * 12'(DECIMAL_BASE) + 12'(digit);
    token_ok   = token_has_digit && !token_bad && (token_value <= 9'd255);
    dst_match  = token_ok && (token_value[7:0] == cfg.own_address);
    src_match  = token_ok && (token_value[7:0] == cfg.expected_source);
    word_new   = word_chars;
    unique case (word_count)
      2'd0:    word_new[7:0]   = item.rx_char;
      2'd1:    word_new[15:8]  = item.rx_char;
      2'd2:    word_new[23:16] = item.rx_char;
      default: word_new        = word_chars;
    endcase
  end

  always_comb begin
    parse_state_next     = parse_state;
    token_value_next     = token_value;
    token_has_digit_next = token_has_digit;
    token_bad_next       = token_bad;
    token_length_next    = token_length;
    word_chars_next      = word_chars;
    word_count_next      = word_count;
    ticks_left_next      = ticks_left;
    final_status_next    = final_status;

    if (item.operation == OP_START) begin
      parse_state_next     = PS_IDLE;
      token_value_next     = '0;
      token_has_digit_next = 1'b0;
      token_bad_next       = 1'b0;
      token_length_next    = '0;
      word_chars_next      = '0;
      word_count_next      = '0;
      ticks_left_next      = cfg.timeout_ticks;
      final_status_next    = RESP_PENDING;
    end else if (final_status == RESP_PENDING) begin
      if (item.operation == OP_CHAR && item.rx_char != CHAR_NUL) begin
        if (item.rx_char == CHAR_AT) begin
          // '@' restarts the frame from any state
          parse_state_next     = PS_DST;
          token_value_next     = '0;
          token_has_digit_next = 1'b0;
          token_bad_next       = 1'b0;
          token_length_next    = '0;
          word_chars_next      = '0;
          word_count_next      = '0;
        end else begin
          unique case (parse_state)
            PS_DST, PS_SRC: begin
              if (item.rx_char == CHAR_SPACE) begin
                token_value_next     = '0;
                token_has_digit_next = 1'b0;
                token_bad_next       = 1'b0;
                token_length_next    = '0;
                if (parse_state == PS_DST) begin
                  // a foreign destination is skipped, keep scanning
                  if (dst_match) parse_state_next = PS_SRC;
                end else begin
                  word_chars_next = '0;
                  word_count_next = '0;
                  parse_state_next = src_match ? PS_WORD : PS_IDLE;
                end
              end else if (item.rx_char == CHAR_LF) begin
                parse_state_next     = PS_IDLE;
                token_value_next     = '0;
                token_has_digit_next = 1'b0;
                token_bad_next       = 1'b0;
                token_length_next    = '0;
                word_chars_next      = '0;
                word_count_next      = '0;
              end else if (token_length < TOKEN_LEN_W'(BUFFER_BYTES - 1)) begin
                token_length_next = token_length + TOKEN_LEN_W'(1);
                if (is_digit) begin
                  token_has_digit_next = 1'b1;
                  if (token_value <= 9'd255) begin
                    token_value_next = (token_prod > 12'd255) ? TOKEN_SAT
                                                              : token_prod[8:0];
                  end
                end else begin
                  token_bad_next = 1'b1;
                end
              end
            end
            PS_WORD: begin
              logic done;
              done = 1'b0;
              if (word_count != 2'd3) begin
                word_chars_next = word_new;
                word_count_next = word_count + 2'd1;
                if (word_count == 2'd1 && word_new == WORD_OK) begin
                  final_status_next = RESP_OK;
                  done = 1'b1;
                end else if (word_count == 2'd2 && word_new == WORD_NOK) begin
                  final_status_next = RESP_NOK;
                  done = 1'b1;
                end
              end
              if (done || item.rx_char == CHAR_LF) begin
                parse_state_next     = PS_IDLE;
                token_value_next     = '0;
                token_has_digit_next = 1'b0;
                token_bad_next       = 1'b0;
                token_length_next    = '0;
                word_chars_next      = '0;
                word_count_next      = '0;
              end
            end
            default: begin
              parse_state_next = parse_state;
            end
          endcase
        end
      end else if (item.operation == OP_TICK) begin
        if (ticks_left <= 16'd1) begin
          ticks_left_next   = '0;
          final_status_next = RESP_TIMEOUT;
        end else begin
          ticks_left_next = ticks_left - 16'd1;
        end
      end
    end
  end

  assign response = final_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= PS_IDLE;
      token_value     <= '0;
      token_has_digit <= 1'b0;
      token_bad       <= 1'b0;
      token_length    <= '0;
      word_chars      <= '0;
      word_count      <= '0;
      ticks_left      <= '0;
      final_status    <= RESP_PENDING;
    end else if (advance) begin
      parse_state     <= parse_state_next;
      token_value     <= token_value_next;
      token_has_digit <= token_has_digit_next;
      token_bad       <= token_bad_next;
      token_length    <= token_length_next;
      word_chars      <= word_chars_next;
      word_count      <= word_count_next;
      ticks_left      <= ticks_left_next;
      final_status    <= final_status_next;
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import aafm_pkg::*;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       has_exp;
    resp_t      exp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] rx_char
  logic [1:0]  s_tuser;   // [1:0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [1:0] response, [7:2] zero
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  ascii_ack_frame_matcher u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // matcher copy: configuration
  logic [7:0]   own_addr_r;
  logic [7:0]   src_addr_r;
  logic [15:0]  timeout_r;
  // matcher copy: parser and status
  parse_state_t pstate;
  logic [8:0]   tok_val;
  logic         tok_digit;
  logic         tok_bad;
  int           tok_len;
  logic [23:0]  word_buf;
  int           word_cnt;
  logic [15:0]  ticks_left;
  resp_t        status;

  resp_t reply_status_q[$];
  item_t frame_q[$];
  row_t  dir_rows [0:24];
  resp_t want;
  int    err_count = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_req = 1'b0;

  function automatic void clear_token();
    tok_val   = '0;
    tok_digit = 1'b0;
    tok_bad   = 1'b0;
    tok_len   = 0;
  endfunction

  function automatic void parser_idle();
    pstate   = PS_IDLE;
    clear_token();
    word_buf = '0;
    word_cnt = 0;
  endfunction

  function automatic void feed_token(logic [7:0] ch);
    int acc;
    // characters past the token buffer are dropped unexamined
    if (tok_len < BUFFER_BYTES - 1) begin
      tok_len++;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        tok_digit = 1'b1;
        if (tok_val <= 9'd255) begin
          acc = int'(tok_val) * DECIMAL_BASE + int'(ch - CHAR_ZERO);
          tok_val = (acc > 255) ? TOKEN_SAT : acc[8:0];
        end
      end else begin
        tok_bad = 1'b1;
      end
    end
  endfunction

  function automatic bit token_is(logic [7:0] target);
    return tok_digit && !tok_bad && tok_val <= 9'd255 && tok_val == {1'b0, target};
  endfunction

  function automatic void parse_char(logic [7:0] ch);
    bit done;
    done = 1'b0;
    if (ch == CHAR_AT) begin
      parser_idle();
      pstate = PS_DST;
    end else begin
      case (pstate)
        PS_DST: begin
          if (ch == CHAR_SPACE) begin
            // foreign destination: keep scanning destination tokens
            if (token_is(own_addr_r)) pstate = PS_SRC;
            clear_token();
          end else if (ch == CHAR_LF) begin
            parser_idle();
          end else begin
            feed_token(ch);
          end
        end
        PS_SRC: begin
          if (ch == CHAR_SPACE) begin
            if (token_is(src_addr_r)) begin
              clear_token();
              word_buf = '0;
              word_cnt = 0;
              pstate   = PS_WORD;
            end else begin
              parser_idle();
            end
          end else if (ch == CHAR_LF) begin
            parser_idle();
          end else begin
            feed_token(ch);
          end
        end
        PS_WORD: begin
          if (word_cnt < 3) begin
            word_buf = word_buf | ({16'd0, ch} << (8 * word_cnt));
            word_cnt++;
            if (word_cnt == 2 && word_buf == WORD_OK) begin
              status = RESP_OK;
              parser_idle();
              done = 1'b1;
            end else if (word_cnt == 3 && word_buf == WORD_NOK) begin
              status = RESP_NOK;
              parser_idle();
              done = 1'b1;
            end
          end
          if (!done && ch == CHAR_LF) parser_idle();
        end
        default: ;
      endcase
    end
  endfunction

  function automatic resp_t matcher_step(op_t op, logic [7:0] ch);
    if (op == OP_START) begin
      parser_idle();
      ticks_left = timeout_r;
      status     = RESP_PENDING;
    end else if (status == RESP_PENDING) begin
      if (op == OP_CHAR && ch != CHAR_NUL) begin
        parse_char(ch);
      end else if (op == OP_TICK) begin
        if (ticks_left <= 16'd1) begin
          ticks_left = '0;
          status     = RESP_TIMEOUT;
        end else begin
          ticks_left--;
        end
      end
    end
    return status;
  endfunction

  // frame building
  function automatic void add_item(op_t op, logic [7:0] ch);
    item_t it;
    it.operation = op;
    it.rx_char   = ch;
    frame_q.push_back(it);
  endfunction

  // line noise: ticks, zero bytes and unused operations between characters
  function automatic void add_char(logic [7:0] ch);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) add_item(OP_TICK, 8'($urandom_range(0, 255)));
    else if (r < 7) add_item(OP_CHAR, CHAR_NUL);
    else if (r < 9) add_item(OP_NONE, 8'($urandom_range(0, 255)));
    add_item(OP_CHAR, ch);
  endfunction

  function automatic logic [7:0] word_letter();
    case ($urandom_range(0, 5))
      0: return CHAR_O;
      1: return CHAR_K;
      2: return CHAR_N;
      3: return CHAR_LF;
      4: return CHAR_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_token(logic [7:0] target);
    int    r;
    int    v;
    int    pad;
    string s;
    r   = $urandom_range(0, 99);
    v   = (r < 80) ? int'(target) : int'($urandom_range(0, 999));
    // long zero runs push digits past the examined prefix
    pad = (r % 20 == 3) ? $urandom_range(20, 30) : $urandom_range(0, 2);
    if (r == 97) pad = 0;
    repeat (pad) add_char(CHAR_ZERO);
    if (r != 97) begin
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
    end
    if (r >= 98) add_char(word_letter());
    add_char(CHAR_SPACE);
  endfunction

  function automatic void build_frame();
    int    r;
    int    w;
    int    pos;
    item_t it;
    frame_q.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat (6) begin
        it.operation = op_t'($urandom_range(0, 3));
        it.rx_char   = 8'($urandom_range(0, 255));
        frame_q.push_back(it);
      end
    end else begin
      if ($urandom_range(0, 9) != 0) add_item(OP_START, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) add_char(8'($urandom_range(0, 255)));
      add_char(CHAR_AT);
      if ($urandom_range(0, 3) == 0) add_token(8'($urandom_range(0, 255)));
      add_token(own_addr_r);
      add_token(src_addr_r);
      w = $urandom_range(0, 9);
      if (w < 4) begin
        add_char(CHAR_O);
        add_char(CHAR_K);
      end else if (w < 7) begin
        add_char(CHAR_N);
        add_char(CHAR_O);
        add_char(CHAR_K);
      end else begin
        repeat (3) add_char(word_letter());
      end
      if ($urandom_range(0, 1) == 1) add_char(CHAR_LF);
      // broken frame: overwrite one transaction with a disruptive char
      if (r >= 88) begin
        pos = $urandom_range(0, frame_q.size() - 1);
        it.operation = OP_CHAR;
        case ($urandom_range(0, 3))
          0: it.rx_char = CHAR_LF;
          1: it.rx_char = CHAR_AT;
          2: it.rx_char = CHAR_SPACE;
          default: it.rx_char = 8'($urandom_range(0, 255));
        endcase
        frame_q[pos] = it;
      end
    end
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(item_t it, logic has_exp, resp_t exp);
    resp_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.operation;
    s_tdata  <= it.rx_char;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = matcher_step(it.operation, it.rx_char);
    reply_status_q.push_back(has_exp ? exp : pred);
    @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] own, logic [7:0] src, logic [15:0] tmo, bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_data  <= {8'd0, own};
    @(negedge clk);
    cfg_index <= CFG_EXPECTED_SOURCE;
    cfg_data  <= {8'd0, src};
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= tmo;
    @(negedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= 16'($urandom_range(0, 65535));
      @(negedge clk);
    end
    cfg_we     <= 1'b0;
    own_addr_r  = own;
    src_addr_r  = src;
    timeout_r   = tmo;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (reply_status_q.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    if (reply_status_q.size() != 0) begin
      $display("%0t: %0d expected responses never arrived", $time, reply_status_q.size());
      err_count++;
    end
    repeat (4) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (reply_status_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %0d", $time, m_tdata);
        err_count++;
      end else begin
        want = reply_status_q.pop_front();
        if (m_tdata !== {6'd0, want}) begin
          $display("%0t: response mismatch, expected %0d got %0d", $time, want, m_tdata);
          err_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int sent;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = OP_CHAR;
    cfg_we     = 1'b0;
    cfg_index  = CFG_OWN_ADDRESS;
    cfg_data   = '0;
    own_addr_r = 8'd0;
    src_addr_r = 8'd0;
    timeout_r  = 16'd300;
    ticks_left = '0;
    status     = RESP_PENDING;
    parser_idle();

    // own 0, source 255, timeout 2
    dir_rows = '{
      {OP_TICK,  CHAR_NUL,   1'b1, RESP_TIMEOUT},  // tick before any start
      {OP_CHAR,  "A",        1'b1, RESP_TIMEOUT},  // held
      {OP_START, 8'hFF,      1'b1, RESP_PENDING},
      {OP_NONE,  8'hFF,      1'b1, RESP_PENDING},
      {OP_CHAR,  CHAR_NUL,   1'b1, RESP_PENDING},
      {OP_CHAR,  CHAR_AT,    1'b0, RESP_PENDING},
      {OP_CHAR,  "1",        1'b0, RESP_PENDING},  // foreign destination
      {OP_CHAR,  CHAR_SPACE, 1'b0, RESP_PENDING},
      {OP_CHAR,  "0",        1'b0, RESP_PENDING},
      {OP_CHAR,  CHAR_SPACE, 1'b0, RESP_PENDING},
      {OP_CHAR,  "2",        1'b0, RESP_PENDING},
      {OP_CHAR,  "5",        1'b0, RESP_PENDING},
      {OP_CHAR,  "5",        1'b0, RESP_PENDING},
      {OP_CHAR,  CHAR_SPACE, 1'b0, RESP_PENDING},
      {OP_CHAR,  CHAR_N,     1'b0, RESP_PENDING},
      {OP_CHAR,  CHAR_O,     1'b0, RESP_PENDING},
      {OP_CHAR,  CHAR_K,     1'b0, RESP_PENDING},
      {OP_TICK,  CHAR_NUL,   1'b0, RESP_PENDING},
      {OP_START, CHAR_NUL,   1'b1, RESP_PENDING},
      {OP_CHAR,  CHAR_AT,    1'b0, RESP_PENDING},
      {OP_CHAR,  "0",        1'b0, RESP_PENDING},
      {OP_CHAR,  CHAR_LF,    1'b0, RESP_PENDING},  // newline aborts
      {OP_TICK,  8'h00,      1'b0, RESP_PENDING},
      {OP_TICK,  8'hFF,      1'b1, RESP_TIMEOUT},
      {OP_START, 8'h80,      1'b1, RESP_PENDING}
    };

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_config(8'd0, 8'd255, 16'd2, 1'b0);
    foreach (dir_rows[i]) begin
      send_item({dir_rows[i].op, dir_rows[i].ch}, dir_rows[i].has_exp, dir_rows[i].exp);
    end
    s_tvalid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case (p)
        0: set_config(8'd255, 8'd0, 16'd1, 1'b0);
        1: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd0, 1'b0);
        2: set_config(8'd0, 8'd255, 16'd65535, 1'b0);
        3: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd300, 1'b1);
        4: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(1, 6)), 1'b0);
        5: set_config(8'd255, 8'd255, 16'd3, 1'b0);
        6: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd0, 1'b0);
        default: set_config(8'd0, 8'd0, 16'($urandom_range(0, 65535)), 1'b0);
      endcase
      // long receiver hold-off while the sender keeps pushing
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < 60) begin
        build_frame();
        foreach (frame_q[i]) send_item(frame_q[i], 1'b0, RESP_PENDING);
        sent += frame_q.size();
      end
      s_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/aafm_pkg.sv
design/aafm_parser.sv
design/ascii_ack_frame_matcher.sv
tb/tb_top.sv
